### design/slhs_pkg.sv
// Shared types and constants for the status LED heartbeat sequencer.
// Holds the channel payload structs, the status code enum and the register indexes.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package slhs_pkg;

  // Width of the configuration times and of the reported wait.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HB_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] HB_ON_RST  = 16'd100;
  localparam logic [CFG_W-1:0] HB_OFF_RST = 16'd2000;
  localparam logic [CFG_W-1:0] FLASH_RST  = 16'd1000;

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Held status codes.
  typedef enum logic [2:0] {
    ST_BOOT    = 3'd0,
    ST_SLEEP   = 3'd1,
    ST_DASH    = 3'd2,
    ST_IDLE    = 3'd3,
    ST_SUCCESS = 3'd4,
    ST_OTHER   = 3'd5
  } status_t;

  // One input transfer.
  typedef struct packed {
    logic       command;
    logic [2:0] status_code;
    logic       idle_mode;
    logic       dashboard_mode;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic             red_on;
    logic             green_on;
    logic             blue_on;
    logic [2:0]       current_status;
    logic             wait_valid;
    logic [CFG_W-1:0] wait_ms;
  } out_t;

  // Configuration bundle handed from the register file to the sequencer.
  typedef struct packed {
    logic [CFG_W-1:0] hb_on_ms;
    logic [CFG_W-1:0] hb_off_ms;
    logic [CFG_W-1:0] flash_dur;
  } cfg_t;

  // True for the statuses that blink.
  function automatic logic is_beat(status_t s);
    return (s == ST_SLEEP) || (s == ST_DASH) || (s == ST_IDLE);
  endfunction

endpackage

### design/slhs_cfg_regs.sv
// Configuration register file of the status LED heartbeat sequencer.
// Depends on slhs_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module slhs_cfg_regs
  import slhs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index past the list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_HB_ON:  cfg_nxt.hb_on_ms  = wr_data;
        CFG_HB_OFF: cfg_nxt.hb_off_ms = wr_data;
        CFG_FLASH:  cfg_nxt.flash_dur = wr_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_on_ms  <= HB_ON_RST;
      cfg_r.hb_off_ms <= HB_OFF_RST;
      cfg_r.flash_dur <= FLASH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/slhs_step.sv
// Sequencer state and step logic of the status LED heartbeat sequencer.
// Depends on slhs_pkg for status_t, in_t, out_t, cfg_t and is_beat.
`timescale 1ns / 1ps

module slhs_step
  import slhs_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  status_t               status_r, status_nxt;
  logic                  lit_r, lit_nxt;
  logic [TIME_WIDTH-1:0] phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic                  flash_r, flash_nxt;

  logic [TIME_WIDTH-1:0] phase_inc, elapsed_inc;
  logic [CFG_W-1:0]      tick_target;
  logic                  flash_done, phase_done;
  logic                  to_idle, to_dash;
  status_t               enter_st;
  logic                  do_enter;
  status_t               set_st;

  // Saturating millisecond counters.
  assign phase_inc   = (phase_r == TIME_MAX) ? phase_r : phase_r + 1'b1;
  assign elapsed_inc = (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;

  assign tick_target = lit_r ? cfg.hb_on_ms : cfg.hb_off_ms;
  assign flash_done  = flash_r && (CMP_W'(elapsed_inc) >= CMP_W'(cfg.flash_dur));
  assign phase_done  = is_beat(status_r) && (CMP_W'(phase_inc) >= CMP_W'(tick_target));

  // Steady-state priority: idle beats dashboard; the mode flags never override boot or success.
  assign to_idle = item.idle_mode && (status_r != ST_IDLE) && (status_r != ST_SUCCESS)
                   && (status_r != ST_BOOT);
  assign to_dash = !item.idle_mode && item.dashboard_mode && (status_r != ST_DASH)
                   && (status_r != ST_SUCCESS) && (status_r != ST_BOOT);

  // Codes past the last one are held as other.
  assign set_st = (item.status_code > 3'(ST_OTHER)) ? ST_OTHER : status_t'(item.status_code);

  // Pick whether this step enters a new status, and which.
  always_comb begin
    do_enter = 1'b0;
    enter_st = set_st;
    if (item.command == CMD_SET) begin
      do_enter = 1'b1;
      enter_st = set_st;
    end else if (flash_done) begin
      do_enter = 1'b1;
      if (item.idle_mode) begin
        enter_st = ST_IDLE;
      end else if (item.dashboard_mode) begin
        enter_st = ST_DASH;
      end else begin
        enter_st = ST_SLEEP;
      end
    end else if (to_idle) begin
      do_enter = 1'b1;
      enter_st = ST_IDLE;
    end else if (to_dash) begin
      do_enter = 1'b1;
      enter_st = ST_DASH;
    end
  end

  // Next state.
  always_comb begin
    status_nxt  = status_r;
    lit_nxt     = lit_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    flash_nxt   = flash_r;
    if (do_enter) begin
      status_nxt  = enter_st;
      elapsed_nxt = '0;
      flash_nxt   = (enter_st == ST_SUCCESS);
      lit_nxt     = is_beat(enter_st);
      if (is_beat(enter_st)) begin
        phase_nxt = '0;
      end else if (item.command == CMD_TICK) begin
        phase_nxt = phase_inc;
      end
    end else begin
      // Plain tick: advance time and toggle the blink when its phase is over.
      elapsed_nxt = elapsed_inc;
      if (phase_done) begin
        phase_nxt = '0;
        lit_nxt   = !lit_r;
      end else begin
        phase_nxt = phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= ST_OTHER;
      lit_r     <= 1'b0;
      phase_r   <= '0;
      elapsed_r <= '0;
      flash_r   <= 1'b0;
    end else if (step_en) begin
      status_r  <= status_nxt;
      lit_r     <= lit_nxt;
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      flash_r   <= flash_nxt;
    end
  end

  // Result from the state after the step.
  logic [CFG_W-1:0] out_target;
  logic [CMP_W-1:0] wait_full;
  logic             out_beat;

  assign out_beat   = is_beat(status_nxt);
  assign out_target = lit_nxt ? cfg.hb_on_ms : cfg.hb_off_ms;
  assign wait_full  = (CMP_W'(phase_nxt) >= CMP_W'(out_target)) ? '0
                      : CMP_W'(out_target) - CMP_W'(phase_nxt);

  always_comb begin
    res                = '0;
    res.current_status = 3'(status_nxt);
    res.wait_valid     = out_beat;
    res.wait_ms        = out_beat ? wait_full[CFG_W-1:0] : '0;
    case (status_nxt)
      ST_BOOT: begin
        res.red_on   = 1'b1;
        res.green_on = 1'b1;
        res.blue_on  = 1'b1;
      end
      ST_SUCCESS: res.green_on = 1'b1;
      ST_SLEEP:   res.blue_on  = lit_nxt;
      ST_DASH:    res.red_on   = lit_nxt;
      ST_IDLE: begin
        res.red_on   = lit_nxt;
        res.green_on = lit_nxt;
      end
      default: res.red_on = 1'b0;
    endcase
  end

endmodule

### design/status_led_heartbeat_sequencer_unit.sv
// Top level of the status LED heartbeat sequencer: input and result registers
// around the step logic. Depends on slhs_pkg, slhs_cfg_regs and slhs_step.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): each transfer is either a
//   one-millisecond tick carrying the idle and dashboard flags, or a set-status
//   command. Result channel (out_valid, out_stall, out_data): exactly one result
//   per input transfer, in order, giving the LED drive, the held status and the
//   time left in the current heartbeat phase.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
//   the heartbeat on time, off time and flash time; cfg_ready is always high.
//   Write it only while no transfer is in flight.
// Timing:
//   A result passes through the input register and then the result register
//   before it is valid on out_data. One transfer per cycle is sustained while
//   out_stall is low; the limit is the state update in slhs_step.
// Reset:
//   Synchronous, active low. Status is other (LED off), counters clear and the
//   configuration returns to 100 / 2000 / 1000 ms.
// Stalls:
//   When out_stall holds the result register, the input register holds its item
//   and in_stall rises once it is full; nothing is lost or repeated.
`timescale 1ns / 1ps

module status_led_heartbeat_sequencer_unit
  import slhs_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  out_t step_res;

  logic in_valid_r, in_valid_nxt;
  in_t  in_data_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  logic out_free, advance, in_take;

  assign cfg_ready = 1'b1;

  slhs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the item in the input register steps when the result register is free.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  slhs_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The wait is reported only for blinking statuses.
  a_wait_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.wait_valid == ((out_data.current_status == 3'(ST_SLEEP)) ||
                   (out_data.current_status == 3'(ST_DASH)) ||
                   (out_data.current_status == 3'(ST_IDLE)))))
    else $error("wait_valid disagrees with the held status");

  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.wait_valid) |-> (out_data.wait_ms == '0))
    else $error("wait_ms nonzero without a heartbeat status");

  // Booting is always white.
  a_boot_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.current_status == 3'(ST_BOOT))) |->
      (out_data.red_on && out_data.green_on && out_data.blue_on))
    else $error("boot status not shown white");

  // A held result with a full input register keeps the input side stalled.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |-> (in_stall && !advance))
    else $error("item stepped while the result register was held");

endmodule

### tb/sv/status_led_heartbeat_sequencer_unit_tb.sv
// Self-checking testbench for status_led_heartbeat_sequencer_unit.
// Drives tick and set-status transfers, predicts each LED result in SystemVerilog
// and compares it field by field. Depends only on slhs_pkg and the unit itself.
`timescale 1ns / 1ps

module status_led_heartbeat_sequencer_unit_tb
  import slhs_pkg::*;
();

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Channels of the unit.
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Pending commands and expected LED results.
  in_t  cmd_q[$];
  out_t led_expect_q[$];

  // Predicted state of the sequencer and its copy of the timing registers.
  status_t          pred_status;
  logic             led_lit;
  logic [CFG_W-1:0] phase_ms;
  logic [CFG_W-1:0] held_ms;
  logic             flash_armed;
  logic [CFG_W-1:0] on_ms;
  logic [CFG_W-1:0] off_ms;
  logic [CFG_W-1:0] flash_len;

  // Bookkeeping.
  int   err_cnt = 0;
  int   accepted = 0;
  int   results_seen = 0;
  int   reg_writes = 0;
  int   hold_count = 0;
  logic in_fire = 1'b0;
  out_t want;

  // Sender and receiver pacing.
  int   burst_left = 8;
  int   gap_left = 0;
  int   hold_left = 0;
  int   stall_tick = 0;
  int   stall_mode = 0;
  bit   hold_done = 1'b0;
  logic stall_next;

  // Mode flags held across random ticks.
  logic idle_flag = 1'b0;
  logic dash_flag = 1'b0;

  status_led_heartbeat_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Heartbeat statuses are the ones that blink.
  function automatic logic blinks(status_t s);
    return (s == ST_SLEEP) || (s == ST_DASH) || (s == ST_IDLE);
  endfunction

  // Switch the predicted status; unknown codes fall back to other.
  function automatic void enter_status(logic [2:0] code);
    status_t s;
    s = (code > ST_OTHER) ? ST_OTHER : status_t'(code);
    pred_status = s;
    held_ms     = '0;
    flash_armed = 1'b0;
    if (blinks(s)) begin
      led_lit  = 1'b1;
      phase_ms = '0;
    end else begin
      led_lit = 1'b0;
      if (s == ST_SUCCESS) begin
        flash_armed = 1'b1;
      end
    end
  endfunction

  // Apply one command to the predicted state and return the LED result it gives.
  function automatic out_t advance_led(in_t c);
    out_t             r;
    logic [CFG_W-1:0] goal;
    if (c.command == CMD_SET) begin
      enter_status(c.status_code);
    end else begin
      // Both elapsed counters stop at their maximum.
      if (phase_ms != '1) phase_ms++;
      if (held_ms != '1) held_ms++;
      if (flash_armed && held_ms >= flash_len) begin
        // The flash ends with a plain fallback and nothing else this tick.
        if (c.idle_mode) enter_status(ST_IDLE);
        else if (c.dashboard_mode) enter_status(ST_DASH);
        else enter_status(ST_SLEEP);
      end else begin
        if (blinks(pred_status)) begin
          goal = led_lit ? on_ms : off_ms;
          if (phase_ms >= goal) begin
            phase_ms = '0;
            led_lit  = !led_lit;
          end
        end
        // Steady-state mode priority: idle beats dashboard.
        if (c.idle_mode && pred_status != ST_IDLE && pred_status != ST_SUCCESS &&
            pred_status != ST_BOOT) begin
          enter_status(ST_IDLE);
        end else if (!c.idle_mode && c.dashboard_mode && pred_status != ST_DASH &&
                     pred_status != ST_SUCCESS && pred_status != ST_BOOT) begin
          enter_status(ST_DASH);
        end
      end
    end
    r = '0;
    case (pred_status)
      ST_BOOT: begin
        r.red_on   = 1'b1;
        r.green_on = 1'b1;
        r.blue_on  = 1'b1;
      end
      ST_SUCCESS: r.green_on = 1'b1;
      ST_SLEEP:   r.blue_on = led_lit;
      ST_DASH:    r.red_on = led_lit;
      ST_IDLE: begin
        r.red_on   = led_lit;
        r.green_on = led_lit;
      end
      default: ;
    endcase
    r.current_status = pred_status;
    r.wait_valid     = blinks(pred_status);
    if (r.wait_valid) begin
      goal      = led_lit ? on_ms : off_ms;
      r.wait_ms = (phase_ms >= goal) ? '0 : goal - phase_ms;
    end
    return r;
  endfunction

  function automatic in_t make_cmd(logic cmd, logic [2:0] code, logic idle, logic dash);
    in_t c;
    c.command        = cmd;
    c.status_code    = code;
    c.idle_mode      = idle;
    c.dashboard_mode = dash;
    return c;
  endfunction

  task automatic check_field(string field, int unsigned wanted, int unsigned got);
    if (wanted != got) begin
      $error("%s: expected %0d, got %0d", field, wanted, got);
      err_cnt++;
    end
  endtask

  // Write one timing register while the unit is idle; the predictor follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HB_ON:  on_ms = val;
      CFG_HB_OFF: off_ms = val;
      CFG_FLASH:  flash_len = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_timing(logic [CFG_W-1:0] on_t, logic [CFG_W-1:0] off_t,
                              logic [CFG_W-1:0] flash_t);
    write_reg(CFG_HB_ON, on_t);
    write_reg(CFG_HB_OFF, off_t);
    write_reg(CFG_FLASH, flash_t);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued command went in and every result came back.
  task automatic drain;
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || led_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Random traffic: mostly ticks with slowly changing mode flags, some set-status
  // commands, and a little noise on the flags.
  task automatic queue_random(int count);
    in_t        c;
    logic [5:0] bits;
    int         i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) idle_flag = ~idle_flag;
      if ($urandom_range(0, 11) == 0) dash_flag = ~dash_flag;
      bits = 6'($urandom);
      c = bits;
      if ($urandom_range(0, 4) == 0) begin
        c.command = CMD_SET;
        if ($urandom_range(0, 1) == 1) begin
          c.status_code = status_t'(3'($urandom_range(1, 4)));
        end
      end else begin
        c.command = CMD_TICK;
        if ($urandom_range(0, 7) != 0) begin
          c.idle_mode      = idle_flag;
          c.dashboard_mode = dash_flag;
        end
      end
      cmd_q.push_back(c);
    end
  endtask

  // Accepted input transfers feed the predictor.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      led_expect_q.push_back(advance_led(in_data));
      accepted++;
    end
  end

  // Driver: bursts of transfers separated by random gaps; a stalled item is held.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, drawn from a randomly chosen mode, with long hold-offs.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if ((!hold_done && results_seen >= 50) || $urandom_range(0, 1999) == 0) begin
        hold_done  = 1'b1;
        hold_left  = $urandom_range(40, 60);
        hold_count++;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = stall_tick[0];
          default: stall_next = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall <= stall_next;
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (led_expect_q.size() == 0) begin
        $error("result transfer with no command pending");
        err_cnt++;
      end else begin
        want = led_expect_q.pop_front();
        check_field("red_on", want.red_on, out_data.red_on);
        check_field("green_on", want.green_on, out_data.green_on);
        check_field("blue_on", want.blue_on, out_data.blue_on);
        check_field("current_status", want.current_status, out_data.current_status);
        check_field("wait_valid", want.wait_valid, out_data.wait_valid);
        check_field("wait_ms", want.wait_ms, out_data.wait_ms);
      end
    end
  end

  // Stimulus sequence and final verdict.
  initial begin
    int p;
    pred_status = ST_OTHER;
    led_lit     = 1'b0;
    phase_ms    = '0;
    held_ms     = '0;
    flash_armed = 1'b0;
    on_ms       = HB_ON_RST;
    off_ms      = HB_OFF_RST;
    flash_len   = FLASH_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset timing: one tick while off, then a sleep heartbeat.
    cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, ST_SLEEP, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    drain();

    // Directed cases with short times.
    apply_timing(16'd2, 16'd3, 16'd2);
    // Booting ignores the mode flags; unknown codes turn the LED off.
    cmd_q.push_back(make_cmd(CMD_SET, ST_BOOT, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_TICK, ST_BOOT, 1'b1, 1'b1));
    cmd_q.push_back(make_cmd(CMD_SET, 3'd6, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, 3'd7, 1'b1, 1'b1));
    // Set status ignores the flags; then a full blink cycle.
    cmd_q.push_back(make_cmd(CMD_SET, ST_SLEEP, 1'b1, 1'b1));
    repeat (5) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    // Mode priority on ticks.
    cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b1));
    cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b1, 1'b1));
    cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    // Success flash expiry to dashboard, idle and sleeping.
    cmd_q.push_back(make_cmd(CMD_SET, ST_SUCCESS, 1'b0, 1'b0));
    repeat (2) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b1));
    cmd_q.push_back(make_cmd(CMD_SET, ST_SUCCESS, 1'b0, 1'b0));
    repeat (2) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b1, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, ST_SUCCESS, 1'b0, 1'b0));
    repeat (2) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    drain();

    // Random phases, each under its own timing: zero, one, maximum, then mixed.
    for (p = 0; p < 8; p++) begin
      case (p)
        0: apply_timing(16'd0, 16'd0, 16'd0);
        1: apply_timing(16'd1, 16'd1, 16'd1);
        2: apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_timing(16'd1, 16'hFFFF, 16'd3);
        default: apply_timing(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                              16'($urandom_range(0, 15)));
      endcase
      queue_random(60);
      drain();
    end

    // Closing sleep run with uneven blink times, then a flash that falls back to idle.
    apply_timing(16'd7, 16'd2, 16'd3);
    cmd_q.push_back(make_cmd(CMD_SET, ST_SLEEP, 1'b0, 1'b0));
    repeat (40) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b0, 1'b0));
    cmd_q.push_back(make_cmd(CMD_SET, ST_SUCCESS, 1'b0, 1'b0));
    repeat (4) cmd_q.push_back(make_cmd(CMD_TICK, ST_OTHER, 1'b1, 1'b0));
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d commands (directed, random and a closing sleep run), %0d results.",
             accepted, results_seen);
    $display("Made %0d register writes and %0d long receiver hold-offs.",
             reg_writes, hold_count);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
